>>> design/tdp_pkg.sv
// Shared types and constants for the trial division prime test unit.
// No dependencies; every other file refers to this package by scoped names.
package tdp_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 31;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture candidate, divisor = 2, square = 4
      logic div_start;   // clear remainder and bit counter
      logic div_step;    // one restoring remainder step
      logic div_next;    // advance divisor and its square
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic below_two;   // value is 0 or 1
      logic sq_above;    // divisor squared exceeds value
      logic div_last;    // current step is the last bit of the value
      logic rem_zero;    // remainder is zero
   } status_type;

endpackage

>>> design/tdp_channels.sv
// Handshake channel interfaces for the request and response sides.
// Depends on tdp_pkg for the default candidate width.
interface tdp_req_if #(parameter int WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] candidate;

   modport source (input clock, input ready, output valid, output candidate);
   modport sink   (input clock, input valid, input candidate, output ready);
endinterface

interface tdp_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic is_prime;

   modport source (input clock, input ready, output valid, output is_prime);
   modport sink   (input clock, input valid, input is_prime, output ready);
endinterface

>>> design/tdp_datapath.sv
// Datapath: value, divisor, divisor square and a bit-serial remainder unit.
// Depends on tdp_pkg for the command and status structs.
module tdp_datapath #(
   parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic [VALUE_WIDTH-1:0] candidate,
   input  tdp_pkg::cmd_type       cmd,
   output tdp_pkg::status_type    status
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [VALUE_WIDTH:0]   square_ff, square_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [VALUE_WIDTH:0]   trial;

   // shift in the next value bit, subtract the divisor when it fits
   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};

   always_comb begin
      value_in   = value_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      square_in  = square_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         value_in   = candidate;
         divisor_in = VALUE_WIDTH'(2);
         square_in  = (VALUE_WIDTH + 1)'(4);
      end
      if (cmd.div_start) begin
         shift_in = value_ff;
         rem_in   = '0;
         count_in = '0;
      end
      if (cmd.div_step) begin
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff + CNT_W'(1);
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = VALUE_WIDTH'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
      end
      if (cmd.div_next) begin
         // (d+1)^2 = d^2 + 2d + 1
         divisor_in = divisor_ff + VALUE_WIDTH'(1);
         square_in  = square_ff + {divisor_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      square_ff  <= square_in;
      rem_ff     <= rem_in;
      count_ff   <= count_in;
   end

   assign status.below_two = (value_ff[VALUE_WIDTH-1:1] == '0);
   assign status.sq_above  = (square_ff > {1'b0, value_ff});
   assign status.div_last  = (count_ff == CNT_W'(VALUE_WIDTH - 1));
   assign status.rem_zero  = (rem_ff == '0);

endmodule

>>> design/tdp_controller.sv
// Controller: sequences the divisor loop and holds the response register.
// Depends on tdp_pkg for the command and status structs.
module tdp_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_prime,
   output tdp_pkg::cmd_type    cmd,
   input  tdp_pkg::status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_TEST   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       verdict_ff, verdict_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_prime_ff, is_prime_in;
   logic       rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      is_prime_in  = is_prime_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_two) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.sq_above) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               cmd.div_next = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               is_prime_in  = verdict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff  <= verdict_in;
      is_prime_ff <= is_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = is_prime_ff;

   a_load_to_check: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_CHECK)
      else $error("load did not enter the check state");

   a_last_step_to_test: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_last) |=> state_ff == ST_TEST)
      else $error("remainder loop overran its last bit");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> rsp_valid_ff && is_prime_ff == $past(verdict_ff))
      else $error("finished verdict not placed in response register");

   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.below_two) |=> !verdict_ff)
      else $error("value below two marked prime");

endmodule

>>> design/trial_division_prime_test_unit.sv
// Trial division prime test: one candidate in, one is_prime bit out.
// Each trial divisor passes through the bit-serial remainder unit
// (VALUE_WIDTH steps per divisor). One candidate is in work at a time; a new
// one is taken once the verdict moves into the response register.
// Reset (synchronous, active high) clears the controller state and response valid.
module trial_division_prime_test_unit #(
   parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tdp_req_if.sink   req_channel,
   tdp_rsp_if.source rsp_channel
);

   tdp_pkg::cmd_type    cmd;
   tdp_pkg::status_type status;

   tdp_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_channel.valid),
      .req_ready    (req_channel.ready),
      .rsp_valid    (rsp_channel.valid),
      .rsp_ready    (rsp_channel.ready),
      .rsp_is_prime (rsp_channel.is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdp_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .candidate (req_channel.candidate[VALUE_WIDTH-1:0]),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> test/testbench.sv
// Self-checking bench for trial_division_prime_test_unit: a directed table, then random
// candidates, each verdict checked against its table entry or a local trial-division predictor.
// Depends on tdp_pkg and the tdp_req_if / tdp_rsp_if channel interfaces.
module testbench;

   localparam int VW = tdp_pkg::VALUE_WIDTH_DEFAULT;
   localparam int RANDOM_COUNT = 100;
   localparam int QUIET_TAIL = 20;
   localparam int HOLD_AT = 30;
   localparam int DRAIN_AT = 60;
   localparam int LONG_HOLD_CYCLES = 20000;
   localparam int SETTLE_CYCLES = 200;
   localparam int SMALL_FACTOR_BOUND = 97;
   localparam int DIRECTED_COUNT = 17;

   typedef struct packed {
      logic [VW-1:0] candidate;
      logic          typed;      // verdict below is given; otherwise predict it
      logic          verdict;
   } probe_row_type;

   typedef struct packed {
      logic [VW-1:0] candidate;
      logic          is_prime;
   } verdict_type;

   logic clock = 1'b0;
   logic reset;

   always #2 clock = ~clock;

   tdp_req_if #(.WIDTH(VW)) req_ch (.clock(clock));
   tdp_rsp_if               rsp_ch (.clock(clock));

   trial_division_prime_test_unit #(.VALUE_WIDTH(VW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_channel(req_ch),
      .rsp_channel(rsp_ch)
   );

   verdict_type pending_verdicts[$];
   int unsigned mismatch_count = 0;
   bit          hold_off_request = 1'b0;
   bit          quiet_tail = 1'b0;

   probe_row_type directed_rows [DIRECTED_COUNT] = '{
      '{31'd0,          1'b1, 1'b0},
      '{31'd1,          1'b1, 1'b0},
      '{31'd2,          1'b1, 1'b1},
      '{31'd3,          1'b1, 1'b1},
      '{31'd4,          1'b1, 1'b0},
      '{31'd5,          1'b0, 1'b0},
      '{31'd9,          1'b0, 1'b0},   // divisor squared equals the value
      '{31'd25,         1'b0, 1'b0},
      '{31'd49,         1'b0, 1'b0},
      '{31'd63001,      1'b0, 1'b0},   // square of a prime
      '{31'd65521,      1'b0, 1'b0},
      '{31'd1073741824, 1'b1, 1'b0},
      '{31'd715827882,  1'b1, 1'b0},
      '{31'd1431655765, 1'b0, 1'b0},
      '{31'd2147483646, 1'b1, 1'b0},
      '{31'd2147483647, 1'b0, 1'b0},   // top value, longest divisor run
      '{31'd7,          1'b0, 1'b0}
   };

   // Exact trial division; d <= v / d keeps the bound free of overflow.
   function automatic logic is_prime_by_division(input logic [VW-1:0] value);
      logic [63:0] v;
      logic [63:0] d;
      v = 64'(value);
      if (v < 64'd2) return 1'b0;
      for (d = 64'd2; d <= v / d; d++) begin
         if (v % d == 64'd0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit has_factor_below(input logic [VW-1:0] value, input int unsigned bound);
      logic [31:0] v;
      logic [31:0] d;
      v = 32'(value);
      for (d = 32'd2; d <= bound; d++) begin
         if (v != d && v % d == 32'd0) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Mostly cheap candidates: small ranges, or full-width values with a small factor.
   function automatic logic [VW-1:0] pick_candidate();
      logic [31:0] raw;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         raw = $urandom_range(0, 4095);
      end else if (kind < 50) begin
         raw = $urandom_range(0, 65535);
      end else begin
         raw = $urandom;
         while (!has_factor_below(raw[VW-1:0], SMALL_FACTOR_BOUND)) raw = $urandom;
      end
      return raw[VW-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("verdict error at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Offer one candidate and hold it until the transfer.
   task automatic offer_candidate(input probe_row_type row);
      verdict_type entry;
      req_ch.valid     <= 1'b1;
      req_ch.candidate <= row.candidate;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      entry.candidate = row.candidate;
      entry.is_prime  = row.typed ? row.verdict : is_prime_by_division(row.candidate);
      pending_verdicts = {pending_verdicts, entry};
   endtask

   task automatic pause_sender(input int unsigned cycles);
      logic [31:0] raw;
      raw = $urandom;
      req_ch.valid     <= 1'b0;
      req_ch.candidate <= raw[VW-1:0];
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet_tail && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 6));
   endtask

   task automatic wait_all_verdicts();
      pause_sender(1);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver: random short stalls, one long hold on request, none in the tail.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      verdict_type oldest;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict %0b with nothing outstanding", rsp_ch.is_prime));
         end else begin
            oldest = pending_verdicts.pop_front();
            if (rsp_ch.is_prime !== oldest.is_prime)
               report_mismatch($sformatf("candidate %0d: is_prime %0b, want %0b",
                                         oldest.candidate, rsp_ch.is_prime, oldest.is_prime));
         end
      end
   end

   initial begin
      probe_row_type row;
      req_ch.valid     <= 1'b0;
      req_ch.candidate <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer_candidate(directed_rows[i]);
         maybe_gap();
      end
      wait_all_verdicts();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == HOLD_AT) hold_off_request = 1'b1;
         if (i == DRAIN_AT) wait_all_verdicts();
         if (i == RANDOM_COUNT - QUIET_TAIL) quiet_tail = 1'b1;
         row.candidate = pick_candidate();
         row.typed     = 1'b0;
         row.verdict   = 1'b0;
         offer_candidate(row);
         maybe_gap();
      end

      wait_all_verdicts();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("trial_division_prime_test_unit: match");
      end else begin
         $display("trial_division_prime_test_unit: mismatch");
      end
      $finish;
   end

   // Watchdog: a run that has not finished by this time is reported as a mismatch.
   initial begin
      #(64'd48_000_000);
      $display("trial_division_prime_test_unit: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
design/tdp_pkg.sv
design/tdp_channels.sv
design/tdp_datapath.sv
design/tdp_controller.sv
design/trial_division_prime_test_unit.sv
test/testbench.sv
